@@ rtl/tcwqs_pkg.sv @@
// Shared constants and codes for the two-class weighted queue scheduler.
package tcwqs_pkg;

  // Default storage shape
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int TAG_WIDTH_DEF   = 32;

  // Fixed field widths
  localparam int OP_W     = 2;
  localparam int BUSY_W   = 7;
  localparam int LIMIT_W  = 7;
  localparam int WEIGHT_W = 4;
  localparam int COUNT_W  = 7;
  localparam int SERVED_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Register reset values
  localparam logic [LIMIT_W-1:0]  QUEUE_LIMIT_RST   = 7'd16;
  localparam logic [WEIGHT_W-1:0] SINGLE_WEIGHT_RST = 4'd4;

  // Served counters stop here
  localparam logic [SERVED_W-1:0] SERVED_MAX = 8'hFF;

  // Item operations
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_SINGLE = 2'd0,
    OP_PUSH_BULK   = 2'd1,
    OP_POP         = 2'd2,
    OP_NONE        = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUEUE_LIMIT   = 1'd0,
    CFG_SINGLE_WEIGHT = 1'd1
  } cfg_idx_t;

endpackage

@@ rtl/tcwqs_ram.sv @@
// Tag store: one write port, one registered read port with write-through.
module tcwqs_ram #(
  parameter int DEPTH = tcwqs_pkg::QUEUE_DEPTH_DEF,
  parameter int WIDTH = tcwqs_pkg::TAG_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the tail entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read every cycle; forward a same-cycle write to the read address
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/two_class_weighted_queue_scheduler.sv @@
// Top level: two tag FIFOs with admission control and weighted pop arbitration.
//
//  channel | signals                                   | direction | handshake
//  --------+-------------------------------------------+-----------+----------------
//  config  | cfg_we, cfg_index, cfg_data               | in        | write on cfg_we
//  item in | opcode, payload, busy_workers             | in        | in_valid/in_ready
//  result  | accepted, pop_valid, pop_data, pop_from_bulk,| out      | out_valid/out_ready
//          | single_open, bulk_open, single_count, bulk_count |     |
//
// One item per cycle sustained while out_ready is high; each item passes the input
// register, then the result register. Each item's push/pop decision, pointer and
// counter update are made while it sits in the input register; the head tag of each
// queue is read ahead from its RAM. Reset clears pointers, counts, served counters,
// valid flags and configuration registers; the tag RAMs are not cleared. A stalled
// result holds the input register; in_ready drops once it is full and cannot advance.
module two_class_weighted_queue_scheduler #(
  parameter int QUEUE_DEPTH = tcwqs_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_WIDTH   = tcwqs_pkg::TAG_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tcwqs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcwqs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tcwqs_pkg::OP_W-1:0]          opcode,
  input  logic [TAG_WIDTH-1:0]                payload,
  input  logic [tcwqs_pkg::BUSY_W-1:0]        busy_workers,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                accepted,
  output logic                                pop_valid,
  output logic [TAG_WIDTH-1:0]                pop_data,
  output logic                                pop_from_bulk,
  output logic                                single_open,
  output logic                                bulk_open,
  output logic [tcwqs_pkg::COUNT_W-1:0]       single_count,
  output logic [tcwqs_pkg::COUNT_W-1:0]       bulk_count
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = ((CNT_W > tcwqs_pkg::BUSY_W) ? CNT_W : tcwqs_pkg::BUSY_W) + 2;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // Configuration registers
  logic [tcwqs_pkg::LIMIT_W-1:0]  queue_limit;
  logic [tcwqs_pkg::WEIGHT_W-1:0] single_weight;

  // Input register
  logic                        iv;
  tcwqs_pkg::op_t              i_op;
  logic [TAG_WIDTH-1:0]        i_tag;
  logic [tcwqs_pkg::BUSY_W-1:0] i_busy;

  // Queue state
  logic [PTR_W-1:0] single_head, single_tail, bulk_head, bulk_tail;
  logic [PTR_W-1:0] single_head_next, single_tail_next, bulk_head_next, bulk_tail_next;
  logic [CNT_W-1:0] single_items, bulk_items, single_items_next, bulk_items_next;
  logic [tcwqs_pkg::SERVED_W-1:0] single_served, bulk_served;
  logic [tcwqs_pkg::SERVED_W-1:0] single_served_next, bulk_served_next;

  // Head tags read ahead
  logic [TAG_WIDTH-1:0] single_head_tag, bulk_head_tag;

  // Decision signals
  logic adv;
  logic s_has, b_has, s_full, b_full;
  logic [SUM_W-1:0] lim_ext, half_ext, sum_now, sum_next;
  logic cont_single, cont_bulk;
  logic push_s, push_b, is_pop, pref_single, pop_any, pop_bulk_sel, pop_s, pop_b;
  logic [tcwqs_pkg::SERVED_W-1:0] ratio, bump_src, bumped;
  logic open_single_next, open_bulk_next;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit   <= tcwqs_pkg::QUEUE_LIMIT_RST;
      single_weight <= tcwqs_pkg::SINGLE_WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (tcwqs_pkg::cfg_idx_t'(cfg_index))
        tcwqs_pkg::CFG_QUEUE_LIMIT:   queue_limit   <= cfg_data[tcwqs_pkg::LIMIT_W-1:0];
        tcwqs_pkg::CFG_SINGLE_WEIGHT: single_weight <= cfg_data[tcwqs_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the input register into the result register
  assign adv      = iv && (!out_valid || out_ready);
  assign in_ready = !iv || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_ready) begin
      iv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      i_op   <= tcwqs_pkg::op_t'(opcode);
      i_tag  <= payload;
      i_busy <= busy_workers;
    end
  end

  // Admission check against current counts
  always_comb begin
    s_has    = (single_items != '0);
    b_has    = (bulk_items != '0);
    s_full   = (single_items == CNT_FULL);
    b_full   = (bulk_items == CNT_FULL);
    lim_ext  = SUM_W'(queue_limit);
    half_ext = SUM_W'(queue_limit >> 1);
    sum_now  = SUM_W'(single_items) + SUM_W'(bulk_items) + SUM_W'(i_busy);
    cont_single = (sum_now >= lim_ext);
    cont_bulk   = cont_single || (SUM_W'(bulk_items) >= half_ext);
  end

  // Decode the operation and pick the queue to pop
  always_comb begin
    push_s = 1'b0;
    push_b = 1'b0;
    is_pop = 1'b0;
    case (i_op)
      tcwqs_pkg::OP_PUSH_SINGLE: push_s = !cont_single && !s_full;
      tcwqs_pkg::OP_PUSH_BULK:   push_b = !cont_bulk && !b_full;
      tcwqs_pkg::OP_POP:         is_pop = 1'b1;
      default: ;
    endcase
    pref_single  = ({4'b0, single_weight} > single_served);
    pop_any      = is_pop && (s_has || b_has);
    pop_bulk_sel = pref_single ? !s_has : b_has;
    pop_s        = pop_any && !pop_bulk_sel;
    pop_b        = pop_any && pop_bulk_sel;
    ratio        = pref_single ? {4'b0, single_weight} : 8'd1;
    bump_src     = pop_bulk_sel ? bulk_served : single_served;
    bumped       = (bump_src == tcwqs_pkg::SERVED_MAX) ? bump_src : bump_src + 8'd1;
  end

  // Next pointers, counts and served counters
  always_comb begin
    single_head_next   = single_head;
    single_tail_next   = single_tail;
    bulk_head_next     = bulk_head;
    bulk_tail_next     = bulk_tail;
    single_items_next  = single_items;
    bulk_items_next    = bulk_items;
    single_served_next = single_served;
    bulk_served_next   = bulk_served;
    if (adv) begin
      if (push_s) begin
        single_tail_next  = (single_tail == PTR_LAST) ? '0 : single_tail + PTR_W'(1);
        single_items_next = single_items + CNT_W'(1);
      end
      if (push_b) begin
        bulk_tail_next  = (bulk_tail == PTR_LAST) ? '0 : bulk_tail + PTR_W'(1);
        bulk_items_next = bulk_items + CNT_W'(1);
      end
      if (pop_s) begin
        single_head_next   = (single_head == PTR_LAST) ? '0 : single_head + PTR_W'(1);
        single_items_next  = single_items - CNT_W'(1);
        single_served_next = bumped;
        if (bumped == ratio) begin
          bulk_served_next = '0;
        end
      end
      if (pop_b) begin
        bulk_head_next   = (bulk_head == PTR_LAST) ? '0 : bulk_head + PTR_W'(1);
        bulk_items_next  = bulk_items - CNT_W'(1);
        bulk_served_next = bumped;
        if (bumped == ratio) begin
          single_served_next = '0;
        end
      end
    end
  end

  // Open flags from the counts after this item
  always_comb begin
    sum_next = SUM_W'(single_items_next) + SUM_W'(bulk_items_next) + SUM_W'(i_busy);
    open_single_next = !(sum_next >= lim_ext);
    open_bulk_next   = open_single_next && !(SUM_W'(bulk_items_next) >= half_ext);
  end

  // Queue state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      single_head   <= '0;
      single_tail   <= '0;
      bulk_head     <= '0;
      bulk_tail     <= '0;
      single_items  <= '0;
      bulk_items    <= '0;
      single_served <= '0;
      bulk_served   <= '0;
    end else begin
      single_head   <= single_head_next;
      single_tail   <= single_tail_next;
      bulk_head     <= bulk_head_next;
      bulk_tail     <= bulk_tail_next;
      single_items  <= single_items_next;
      bulk_items    <= bulk_items_next;
      single_served <= single_served_next;
      bulk_served   <= bulk_served_next;
    end
  end

  // Tag stores, read ahead at the next head
  tcwqs_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(TAG_WIDTH)) u_single_ram (
    .clk   (clk),
    .we    (adv && push_s),
    .waddr (single_tail),
    .wdata (i_tag),
    .raddr (single_head_next),
    .rdata (single_head_tag)
  );

  tcwqs_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(TAG_WIDTH)) u_bulk_ram (
    .clk   (clk),
    .we    (adv && push_b),
    .waddr (bulk_tail),
    .wdata (i_tag),
    .raddr (bulk_head_next),
    .rdata (bulk_head_tag)
  );

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      accepted      <= push_s || push_b;
      pop_valid     <= pop_any;
      pop_data      <= pop_s ? single_head_tag : (pop_b ? bulk_head_tag : '0);
      pop_from_bulk <= pop_b;
      single_open   <= open_single_next;
      bulk_open     <= open_bulk_next;
      single_count  <= tcwqs_pkg::COUNT_W'(single_items_next);
      bulk_count    <= tcwqs_pkg::COUNT_W'(bulk_items_next);
    end
  end

  // Counts stay within the queue depth
  assert property (@(posedge clk) disable iff (rst)
    (single_items <= CNT_FULL) && (bulk_items <= CNT_FULL))
    else $error("queue count beyond depth");

  // A result never reports both a push and a pop
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && pop_valid))
    else $error("push and pop in one result");

  // A bulk pop takes exactly one item off the bulk queue
  assert property (@(posedge clk) disable iff (rst)
    (adv && pop_b && !push_b) |=> (bulk_items == $past(bulk_items) - CNT_W'(1)))
    else $error("bulk count not decremented on pop");

  // Counts and served counters hold while no item advances
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(single_items) && $stable(bulk_items) && $stable(single_served)
              && $stable(bulk_served)))
    else $error("queue state changed without an item");

endmodule
